// ----- src/ple_pkg.sv -----
package ple_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int TOKEN_W     = 8;
   localparam int VAR_W       = 52;
   localparam int VAR_IDX_W   = $clog2(VAR_W);
   localparam int LETTERS     = 26;

   localparam logic [TOKEN_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [TOKEN_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [TOKEN_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [TOKEN_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [TOKEN_W-1:0] CH_OR      = 8'h56; // 'V'
   localparam logic [TOKEN_W-1:0] CH_NOT     = 8'h7E; // '~'
   localparam logic [TOKEN_W-1:0] CH_AND     = 8'h26; // '&'
   localparam logic [TOKEN_W-1:0] CH_IMP     = 8'h3E; // '>'
   localparam logic [TOKEN_W-1:0] CH_EQV     = 8'h3C; // '<'

   typedef enum logic [2:0] {
      TK_VAR,
      TK_NOT,
      TK_AND,
      TK_OR,
      TK_IMP,
      TK_EQV,
      TK_BAD
   } token_kind_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_UNDERFLOW      = 3'd1,
      ST_BAD_CONNECTIVE = 3'd2,
      ST_DEPTH          = 3'd3,
      ST_OVERFLOW       = 3'd4
   } status_type;

   typedef struct packed {
      token_kind_type kind;
      logic           var_value;
   } token_info_type;

   typedef struct packed {
      logic       truth_value;
      status_type status;
   } result_type;

endpackage

// ----- src/postfix_logic_expression_evaluator.sv -----
// A last token's result is loaded into the result register as that token leaves the input register.
// Throughput: one token per cycle while no last token waits on the result register; the stack update is a single
// registered step between the input register and the result register.
// A stalled result blocks only a last token; other tokens keep flowing.
// Reset (synchronous, active high) empties the stack, clears the error and the
// variable register, and drops both valid flags.
module postfix_logic_expression_evaluator
   import ple_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [VAR_W-1:0]   csr_variable_values,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [TOKEN_W-1:0] req_token,
   input  logic               req_last_token,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_truth_value,
   output logic [2:0]         rsp_status
);

   // variable assignment register, one truth bit per letter
   logic [VAR_W-1:0]   vars_ff;

   // input stage
   logic               in_valid_ff, in_valid_in;
   logic [TOKEN_W-1:0] token_ff;
   logic               last_ff;

   // result stage
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;

   token_info_type     info;
   result_type         result;
   logic               out_free;
   logic               advance;
   logic               req_xfer;

   // config writes are always taken
   assign csr_ready = 1'b1;

   // the input stage moves on unless it holds a last token and the result
   // register is still occupied
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!last_ff || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance && last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   ple_token_decode u_decode (
      .token           (token_ff),
      .variable_values (vars_ff),
      .info            (info)
   );

   ple_eval_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .info       (info),
      .last_token (last_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vars_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            vars_ff <= csr_variable_values;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         token_ff <= req_token;
         last_ff  <= req_last_token;
      end
      if (advance && last_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_truth_value = rsp_ff.truth_value;
   assign rsp_status      = rsp_ff.status;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

   a_result_only_from_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(advance && last_ff) |=> !rsp_valid_ff)
      else $error("result raised without a last token");

   a_bad_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |-> !rsp_ff.truth_value)
      else $error("true value reported with an error status");

endmodule

// ----- src/ple_token_decode.sv -----
module ple_token_decode
   import ple_pkg::*;
(
   input  logic [TOKEN_W-1:0] token,
   input  logic [VAR_W-1:0]   variable_values,
   output token_info_type     info
);

   logic [TOKEN_W-1:0]   upper_off;
   logic [TOKEN_W-1:0]   lower_off;
   logic [VAR_IDX_W-1:0] var_idx;
   logic                 is_upper;
   logic                 is_lower;

   assign upper_off = token - CH_UPPER_A;
   assign lower_off = token - CH_LOWER_A;
   assign is_upper  = (token >= CH_UPPER_A) && (token <= CH_UPPER_Z) && (token != CH_OR);
   assign is_lower  = (token >= CH_LOWER_A) && (token <= CH_LOWER_Z);

   always_comb begin
      var_idx = is_lower ? VAR_IDX_W'(lower_off + TOKEN_W'(LETTERS))
                         : VAR_IDX_W'(upper_off);
      info.var_value = variable_values[var_idx];
      if (is_upper || is_lower) begin
         info.kind = TK_VAR;
      end else begin
         unique case (token)
            CH_NOT:  info.kind = TK_NOT;
            CH_AND:  info.kind = TK_AND;
            CH_OR:   info.kind = TK_OR;
            CH_IMP:  info.kind = TK_IMP;
            CH_EQV:  info.kind = TK_EQV;
            default: info.kind = TK_BAD;
         endcase
      end
   end

endmodule

// ----- src/ple_eval_core.sv -----
module ple_eval_core
   import ple_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  token_info_type info,
   input  logic           last_token,
   output result_type     result
);

   // top of stack lives at index 0; push and pop shift the whole row
   logic [STACK_DEPTH-1:0] stack_ff, stack_in;
   logic [DEPTH_W-1:0]     depth_ff, depth_in, depth_upd;
   status_type             err_ff, err_in, err_upd;
   logic                   p, q, r;

   assign q = stack_ff[0];
   assign p = stack_ff[1];

   always_comb begin
      case (info.kind)
         TK_AND:  r = p & q;
         TK_OR:   r = p | q;
         TK_IMP:  r = ~p | q;
         default: r = ~(p ^ q);
      endcase
   end

   always_comb begin
      stack_in  = stack_ff;
      depth_upd = depth_ff;
      err_upd   = err_ff;
      if (err_ff == ST_OK) begin
         if (info.kind == TK_VAR) begin
            if (depth_ff == DEPTH_W'(STACK_DEPTH)) begin
               err_upd = ST_OVERFLOW;
            end else begin
               for (int i = STACK_DEPTH - 1; i > 0; i--) begin
                  stack_in[i] = stack_ff[i-1];
               end
               stack_in[0] = info.var_value;
               depth_upd   = depth_ff + DEPTH_W'(1);
            end
         end else if (info.kind == TK_NOT) begin
            if (depth_ff == '0) begin
               err_upd = ST_UNDERFLOW;
            end else begin
               stack_in[0] = ~stack_ff[0];
            end
         end else if (depth_ff < DEPTH_W'(2)) begin
            err_upd = ST_UNDERFLOW;
         end else if (info.kind == TK_BAD) begin
            err_upd = ST_BAD_CONNECTIVE;
         end else begin
            for (int i = 1; i < STACK_DEPTH - 1; i++) begin
               stack_in[i] = stack_ff[i+1];
            end
            stack_in[STACK_DEPTH-1] = 1'b0;
            stack_in[0]             = r;
            depth_upd               = depth_ff - DEPTH_W'(1);
         end
      end

      result.truth_value = 1'b0;
      if (err_upd != ST_OK) begin
         result.status = err_upd;
      end else if (depth_upd != DEPTH_W'(1)) begin
         result.status = ST_DEPTH;
      end else begin
         result.status      = ST_OK;
         result.truth_value = stack_in[0];
      end

      // expression closes: back to empty and error free
      if (last_token) begin
         depth_in = '0;
         err_in   = ST_OK;
      end else begin
         depth_in = depth_upd;
         err_in   = err_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         err_ff   <= ST_OK;
      end else if (advance) begin
         depth_ff <= depth_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stack_ff <= stack_in;
      end
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && last_token |=> depth_ff == '0 && err_ff == ST_OK)
      else $error("state not cleared after last token");

   a_error_freezes: assert property (@(posedge clock) disable iff (reset)
      advance && !last_token && err_ff != ST_OK |=> $stable(depth_ff) && $stable(err_ff))
      else $error("state moved while an error was latched");

endmodule
